FILE: hdl/rid_pkg.sv
// shared constants and types for the run-length image decoder
package rid_pkg;

  localparam int IMAGE_BYTES = 1024;
  localparam int POS_W       = $clog2(IMAGE_BYTES + 1);
  localparam int CMP_W       = (POS_W > 8) ? POS_W : 8;
  localparam int LEN_W       = 8;
  localparam int CNT_W       = 4;
  localparam int CHUNK_MAX   = 8;
  localparam int REPEAT_BIAS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0]       value;
    logic [LEN_W-1:0] len;
    logic             done;
  } cmd_t;

endpackage

FILE: hdl/rid_fifo.sv
// short command queue between the stream parser and the run expander
module rid_fifo import rid_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full      = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/rid_front.sv
// stream parser: header decode, literal tracking and image position
module rid_front import rid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       push,
  output cmd_t       push_data,
  input  logic       full
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_REPEAT  = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  logic [1:0]       phase, phase_next;
  logic [LEN_W-1:0] literal_left, literal_left_next;
  logic [LEN_W-1:0] repeat_len, repeat_len_next;
  logic [POS_W-1:0] position, position_next;

  logic             accept;
  logic [POS_W-1:0] pos_inc;
  logic             lit_done;
  logic [CMP_W-1:0] room;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] pos_ext;
  logic             rep_done;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  assign pos_inc  = position + 1'b1;
  assign lit_done = (pos_inc >= POS_W'(IMAGE_BYTES));
  assign pos_ext  = CMP_W'(position);
  assign room     = CMP_W'(IMAGE_BYTES) - pos_ext;
  assign len_ext  = CMP_W'(repeat_len);
  assign rep_done = (len_ext >= room);

  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    repeat_len_next   = repeat_len;
    position_next     = position;
    push              = 1'b0;
    push_data.value   = in_byte;
    push_data.len     = LEN_W'(1);
    push_data.done    = 1'b0;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (in_byte[7]) begin
            literal_left_next = LEN_W'(~in_byte) + LEN_W'(1);
            phase_next        = PH_LITERAL;
          end else begin
            repeat_len_next = LEN_W'(in_byte) + LEN_W'(REPEAT_BIAS);
            phase_next      = PH_REPEAT;
          end
        end
        PH_DISCARD: begin
          if (literal_left != '0) begin
            literal_left_next = literal_left - 1'b1;
          end
          if (literal_left <= LEN_W'(1)) begin
            phase_next = PH_HEADER;
          end
        end
        PH_LITERAL: begin
          push           = 1'b1;
          push_data.done = lit_done;
          position_next  = lit_done ? '0 : pos_inc;
          if (literal_left != '0) begin
            literal_left_next = literal_left - 1'b1;
          end
          if (literal_left <= LEN_W'(1)) begin
            phase_next = PH_HEADER;
          end else if (lit_done) begin
            phase_next = PH_DISCARD;
          end
        end
        default: begin
          push            = 1'b1;
          push_data.done  = rep_done;
          push_data.len   = rep_done ? LEN_W'(room) : repeat_len;
          position_next   = rep_done ? '0 : POS_W'(pos_ext + len_ext);
          repeat_len_next = '0;
          phase_next      = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      literal_left <= '0;
      repeat_len   <= '0;
      position     <= '0;
    end else begin
      phase        <= phase_next;
      literal_left <= literal_left_next;
      repeat_len   <= repeat_len_next;
      position     <= position_next;
    end
  end

endmodule

FILE: hdl/rid_back.sv
// run expander: splits each command into chunks of up to eight bytes
module rid_back import rid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] copies,
  output logic             last_of_input,
  output logic             image_done
);

  logic             active;
  logic [7:0]       value;
  logic [LEN_W-1:0] left;
  logic             done;

  logic             emit;
  logic             is_last;
  logic [CNT_W-1:0] cnt;

  assign emit    = active && (!out_valid || out_ready);
  assign is_last = (left <= LEN_W'(CHUNK_MAX));
  assign cnt     = is_last ? CNT_W'(left) : CNT_W'(CHUNK_MAX);
  assign pop     = cmd_valid && (!active || (emit && is_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      value <= cmd.value;
      left  <= cmd.len;
      done  <= cmd.done;
    end else if (emit) begin
      left <= left - LEN_W'(cnt);
    end
    if (emit) begin
      out_byte      <= value;
      copies        <= cnt;
      last_of_input <= is_last;
      image_done    <= is_last && done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/rle_image_decoder_top.sv
// run-length image decoder top level
// a byte's result passes through the command queue, the expander's command registers and its output registers
// throughput: one input byte per cycle while the command queue has room
// a repeat run is given out in chunks of up to eight bytes, one chunk per cycle while out_ready is high
// reset: synchronous; clears parse phase, image position, queue and output valid
module rle_image_decoder_top import rid_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [CNT_W-1:0] copies,
  output logic             last_of_input,
  output logic             image_done
);

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t pop_data;
  logic not_empty;

  rid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  rid_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  rid_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (not_empty),
    .cmd           (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .copies        (copies),
    .last_of_input (last_of_input),
    .image_done    (image_done)
  );

endmodule
